/* hdl/ffpa_pkg.sv */
package ffpa_pkg;

  localparam int CFG_W    = 13;
  localparam int NEED_W   = 16;
  localparam int DIV_W    = CFG_W + 10;

  typedef logic        cmd_t;
  typedef logic [15:0] size_kb_t;
  typedef logic [9:0]  page_idx_t;
  typedef logic [7:0]  alloc_start_t;
  typedef logic [10:0] kb_t;
  typedef logic [CFG_W-1:0] ram_mb_t;

  localparam cmd_t CMD_ALLOC = 1'b0;
  localparam cmd_t CMD_FREE  = 1'b1;

endpackage

/* hdl/ffpa_if.sv */
interface ffpa_in_if;
  import ffpa_pkg::*;

  logic      valid;
  logic      ready;
  cmd_t      cmd;
  size_kb_t  size_kb;
  page_idx_t free_start;

  modport source (output valid, output cmd, output size_kb, output free_start, input ready);
  modport sink   (input valid, input cmd, input size_kb, input free_start, output ready);
endinterface

interface ffpa_out_if;
  import ffpa_pkg::*;

  logic         valid;
  logic         ready;
  logic         ok;
  alloc_start_t alloc_start;
  kb_t          used_kb;
  kb_t          free_kb;

  modport source (output valid, output ok, output alloc_start, output used_kb, output free_kb,
                  input ready);
  modport sink   (input valid, input ok, input alloc_start, input used_kb, input free_kb,
                  output ready);
endinterface

/* hdl/ffpa_div.sv */
module ffpa_div #(
  parameter int DW      = 23,
  parameter int DIVISOR = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);
  // floor division by a constant: multiply by the reciprocal rounded up, exact for DW-bit
  // dividends since the rounding error stays below 2**(SH-DW)
  localparam int          SH    = DW + $clog2(DIVISOR);
  localparam int          PW    = DW + SH + 1;
  localparam logic [SH:0] RECIP =
    (SH + 1)'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [DW-1:0] dvd_q;
  logic [DW-1:0] quo_q;
  logic          busy_q;
  logic          done_q;
  logic [PW-1:0] product;

  assign product = PW'(dvd_q) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q && !start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (busy_q) begin
      quo_q <= product[SH +: DW];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

/* hdl/ffpa_map.sv */
module ffpa_map #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);
  logic mem [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* hdl/first_fit_page_allocator.sv */
// First-fit page allocator over a one-bit-per-page usage map held in a single-port-write
// memory. After reset the block sweeps the map clear one page a cycle and takes no beat
// meanwhile; a write of the RAM size register works out the managed page count by a
// reciprocal multiply, then runs the same sweep. One item is then worked at a time: accept it,
// turn the size into pages by the same multiply, then a page-serial walk through the map, one
// page a cycle, and load the result once the output register is free. An allocate scans the
// managed pages for a run and then marks each page granted; a free clears each used page
// released within the managed range. A result is held in an output register, so the next
// item is accepted while it waits.
module first_fit_page_allocator #(
  parameter int MAP_PAGES = 256,
  parameter int PAGE_KB   = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  ffpa_pkg::ram_mb_t cfg_wdata_i,
  ffpa_in_if.sink           in_i,
  ffpa_out_if.source        out_o
);
  import ffpa_pkg::*;

  localparam int AW    = (MAP_PAGES > 1) ? $clog2(MAP_PAGES) : 1;
  localparam int CNT_W = $clog2(MAP_PAGES + 1);
  localparam int XW    = (CNT_W > 10) ? CNT_W : 10;
  localparam int RESET_MANAGED = ((1024 / PAGE_KB) > MAP_PAGES) ? MAP_PAGES : (1024 / PAGE_KB);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_CDIV  = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_NDIV  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_FREE  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [XW-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]  run_inc;
  logic [AW-1:0]     end_q, end_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  managed_q, managed_d;
  cmd_t              cmd_q, cmd_d;
  logic              ok_q, ok_d;
  logic [XW-1:0]     start_q, start_d;

  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  alloc_start_t      out_start_q, out_start_d;
  kb_t               out_used_q, out_used_d;
  kb_t               out_free_q, out_free_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_wdata;
  logic              rd_data;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  ffpa_div #(
    .DW      (DIV_W),
    .DIVISOR (PAGE_KB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // read data always belongs to the page that idx_q points at
  ffpa_map #(
    .DEPTH (MAP_PAGES),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_d[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign run_inc    = run_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    run_d        = run_q;
    end_d        = end_q;
    need_d       = need_q;
    used_d       = used_q;
    managed_d    = managed_q;
    cmd_d        = cmd_q;
    ok_d         = ok_q;
    start_d      = start_q;
    out_valid_d  = out_valid_q;
    out_ok_d     = out_ok_q;
    out_start_d  = out_start_q;
    out_used_d   = out_used_q;
    out_free_d   = out_free_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q[AW-1:0];
    mem_wdata    = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(in_i.size_kb) + DIV_W'(PAGE_KB - 1);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q[AW-1:0] == AW'(MAP_PAGES - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_CDIV: begin
        if (div_done) begin
          managed_d = (div_quo > DIV_W'(MAP_PAGES)) ? CNT_W'(MAP_PAGES)
                                                    : div_quo[CNT_W-1:0];
          idx_d     = '0;
          state_d   = S_CLEAR;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          div_start = 1'b1;
          cmd_d     = in_i.cmd;
          idx_d     = XW'(in_i.free_start);
          state_d   = S_NDIV;
        end
      end
      S_NDIV: begin
        if (div_done) begin
          need_d  = div_quo[NEED_W-1:0];
          run_d   = '0;
          ok_d    = 1'b0;
          start_d = '0;
          if (cmd_q == CMD_ALLOC) begin
            idx_d   = '0;
            state_d = (div_quo[NEED_W-1:0] == '0) ? S_RESP : S_SCAN;
          end else begin
            state_d = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (idx_q >= XW'(managed_q)) begin
          start_d = '0;
          state_d = S_RESP;
        end else if (!rd_data) begin
          run_d = run_inc;
          if (run_q == '0) begin
            start_d = idx_q;
          end
          if (NEED_W'(run_inc) == need_q) begin
            // run complete: rewind to its first page and mark it
            ok_d    = 1'b1;
            end_d   = idx_q[AW-1:0];
            idx_d   = (run_q == '0) ? idx_q : start_q;
            state_d = S_MARK;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          run_d = '0;
          idx_d = idx_q + 1'b1;
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        if (idx_q[AW-1:0] == end_q) begin
          used_d  = used_q + need_q[CNT_W-1:0];
          state_d = S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FREE: begin
        if ((idx_q >= XW'(managed_q)) || (NEED_W'(run_q) == need_q)) begin
          ok_d    = 1'b1;
          state_d = S_RESP;
        end else begin
          if (rd_data) begin
            mem_we = 1'b1;
            used_d = used_q - 1'b1;
          end
          idx_d = idx_q + 1'b1;
          run_d = run_inc;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_ok_d    = ok_q;
          out_start_d = start_q[7:0];
          out_used_d  = 11'(32'(used_q) * 32'(PAGE_KB));
          out_free_d  = 11'(32'(managed_q - used_q) * 32'(PAGE_KB));
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // size register write: recompute managed pages, then sweep the map clear
    if (cfg_we_i) begin
      div_start    = 1'b1;
      div_dividend = {cfg_wdata_i, 10'b0};
      used_d       = '0;
      state_d      = S_CDIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      used_q      <= '0;
      managed_q   <= CNT_W'(RESET_MANAGED);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      used_q      <= used_d;
      managed_q   <= managed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q       <= run_d;
    end_q       <= end_d;
    need_q      <= need_d;
    cmd_q       <= cmd_d;
    ok_q        <= ok_d;
    start_q     <= start_d;
    out_ok_q    <= out_ok_d;
    out_start_q <= out_start_d;
    out_used_q  <= out_used_d;
    out_free_q  <= out_free_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ok          = out_ok_q;
  assign out_o.alloc_start = out_start_q;
  assign out_o.used_kb     = out_used_q;
  assign out_o.free_kb     = out_free_q;
endmodule
